/* design/lnrt_pkg.sv */
// ----------------------------------------------------------------------------
// LRU name table package
// Request codes, result codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package lnrt_pkg;

   typedef enum logic [2:0] {
      REQ_LOOKUP_VAR = 3'd0,
      REQ_LOOKUP_REL = 3'd1,
      REQ_INSERT     = 3'd2,
      REQ_DELETE     = 3'd3,
      REQ_CLEAR      = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_EXTERNAL = 2'd0,
      KIND_IMPLICIT = 2'd1,
      KIND_INTERNAL = 2'd2
   } kind_code_type;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_INSERTED = 2'd1,
      ST_MISS     = 2'd2,
      ST_DONE     = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_ACT,
      S_DELETE,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request
      logic match;       // register the match vectors
      logic act;         // perform the single-slot update
      logic del_step;    // free the next matching slot
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic del_pending; // matching slots remain for the delete
   } stat_type;

endpackage

/* design/lnrt_ctrl.sv */
// ----------------------------------------------------------------------------
// LRU name table controller
// Sequences capture, compare, update, delete sweep and result hand-off.
// ----------------------------------------------------------------------------
module lnrt_ctrl
   import lnrt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_fire,
   input  logic     out_fire,
   input  logic     is_delete,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     in_ready,
   output logic     out_valid
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (in_fire) state_in = S_MATCH;
         S_MATCH:  state_in = is_delete ? S_DELETE : S_ACT;
         S_ACT:    state_in = S_OUT;
         S_DELETE: if (!stat.del_pending) state_in = S_OUT;
         S_OUT:    if (out_fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_fire;
         end
         S_MATCH:  cmd.match = 1'b1;
         S_ACT:    cmd.act = 1'b1;
         S_DELETE: cmd.del_step = stat.del_pending;
         S_OUT:    out_valid = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* design/lnrt_dp.sv */
// ----------------------------------------------------------------------------
// LRU name table datapath
// Slot keys, marks, recency ranks, compare logic and the result register.
// ----------------------------------------------------------------------------
module lnrt_dp
   import lnrt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [2:0]    req_type_i,
   input  logic [1:0]    kind_i,
   input  logic [31:0]   vh_i,
   input  logic [63:0]   vl_i,
   input  logic [31:0]   rh_i,
   input  logic [63:0]   rl_i,
   input  logic          rel_exists_i,
   output stat_type      stat,
   output logic          is_delete,
   output logic [1:0]    status_o,
   output logic [4:0]    slot_o,
   output logic [4:0]    removed_o
);

   localparam int IW = $clog2(ENTRIES);

   // Captured request.
   logic [2:0]  req_ff;
   logic [1:0]  kind_ff;
   logic [31:0] vh_ff, rh_ff;
   logic [63:0] vl_ff, rl_ff;
   logic        rex_ff;

   // Slot storage; the internal slot sits at index ENTRIES.
   logic [31:0] vkh_ff [ENTRIES+1];
   logic [63:0] vkl_ff [ENTRIES+1];
   logic [31:0] rkh_ff [ENTRIES+1];
   logic [63:0] rkl_ff [ENTRIES+1];
   logic [ENTRIES:0]   used_ff;
   logic [ENTRIES-1:0] refd_ff;
   logic [IW-1:0]      rank_ff [ENTRIES];

   // Registered compare results.
   logic [ENTRIES-1:0] vhit_ff, rhit_ff, old_ff;

   logic [1:0] status_ff;
   logic [4:0] slot_ff, removed_ff;

   assign is_delete = (req_ff == REQ_DELETE);
   assign stat.del_pending = |rhit_ff;
   assign status_o  = status_ff;
   assign slot_o    = slot_ff;
   assign removed_o = removed_ff;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_type_i;
         kind_ff <= kind_i;
         vh_ff   <= vh_i;
         vl_ff   <= vl_i;
         rh_ff   <= rh_i;
         rl_ff   <= rl_i;
         rex_ff  <= rel_exists_i;
      end
   end

   // Compare vectors over all external slots.
   logic [ENTRIES-1:0] vhit_in, rhit_in, old_in;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         vhit_in[i] = used_ff[i] && vkh_ff[i] == vh_ff && vkl_ff[i] == vl_ff;
         rhit_in[i] = used_ff[i] && rkh_ff[i] == rh_ff && rkl_ff[i] == rl_ff;
         old_in[i]  = (rank_ff[i] == '0);
      end
   end

   // Index of the lowest set bit of a vector, or zero if no bit is set.
   function automatic logic [IW-1:0] first_idx(input logic [ENTRIES-1:0] v);
      logic [IW-1:0] r;
      r = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) r = IW'(i);
      end
      return r;
   endfunction

   // Single-slot decision made in the update step.
   logic          lk_rel, hit_any, do_new, do_write, do_ref, do_int;
   logic [IW-1:0] tgt, del_idx;
   logic [1:0]    st_in;
   always_comb begin
      lk_rel   = (req_ff == REQ_LOOKUP_REL);
      hit_any  = lk_rel ? |rhit_ff : |vhit_ff;
      tgt      = first_idx(old_ff);
      do_new   = 1'b0;
      do_write = 1'b0;
      do_ref   = 1'b0;
      do_int   = 1'b0;
      st_in    = ST_MISS;
      case (req_ff)
         REQ_LOOKUP_VAR, REQ_LOOKUP_REL: begin
            if (hit_any) begin
               tgt    = first_idx(lk_rel ? rhit_ff : vhit_ff);
               do_new = 1'b1;
               do_ref = 1'b1;
               st_in  = ST_HIT;
            end else if (!lk_rel && rex_ff) begin
               do_new   = 1'b1;
               do_write = 1'b1;
               st_in    = ST_INSERTED;
            end
         end
         REQ_INSERT: begin
            if (kind_ff == KIND_INTERNAL) begin
               do_int = 1'b1;
               st_in  = ST_INSERTED;
            end else if (kind_ff == KIND_EXTERNAL || kind_ff == KIND_IMPLICIT) begin
               if (kind_ff == KIND_EXTERNAL && |vhit_ff) begin
                  tgt    = first_idx(vhit_ff);
                  do_ref = 1'b1;
               end
               do_new   = 1'b1;
               do_write = 1'b1;
               st_in    = ST_INSERTED;
            end
         end
         REQ_DELETE, REQ_CLEAR: st_in = ST_DONE;
         default: st_in = ST_MISS;
      endcase
      del_idx = first_idx(rhit_ff);
   end

   logic implicit_wr;
   assign implicit_wr = (req_ff == REQ_LOOKUP_VAR);

   // Slot key writes.
   always_ff @(posedge clock) begin
      if (cmd.act && do_write) begin
         vkh_ff[tgt] <= vh_ff;
         vkl_ff[tgt] <= vl_ff;
         rkh_ff[tgt] <= implicit_wr ? vh_ff : rh_ff;
         rkl_ff[tgt] <= implicit_wr ? vl_ff : rl_ff;
      end
      if (cmd.act && do_int) begin
         vkh_ff[ENTRIES] <= vh_ff;
         vkl_ff[ENTRIES] <= vl_ff;
         rkh_ff[ENTRIES] <= rh_ff;
         rkl_ff[ENTRIES] <= rl_ff;
      end
   end

   // Marks, ranks, compare vectors and result.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         refd_ff    <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= IW'(i);
         rhit_ff    <= '0;
         vhit_ff    <= '0;
         old_ff     <= '0;
         status_ff  <= ST_MISS;
         slot_ff    <= '0;
         removed_ff <= '0;
      end else begin
         if (cmd.match) begin
            vhit_ff    <= vhit_in;
            rhit_ff    <= rhit_in;
            old_ff     <= old_in;
            removed_ff <= '0;
         end
         if (cmd.act) begin
            status_ff <= st_in;
            slot_ff   <= do_int ? 5'(ENTRIES) :
                         ((do_new) ? 5'(tgt) : 5'd0);
            if (do_int) used_ff[ENTRIES] <= 1'b1;
            if (do_write) used_ff[tgt] <= 1'b1;
            if (do_ref) refd_ff[tgt] <= 1'b1;
            if (req_ff == REQ_CLEAR) refd_ff <= '0;
            if (do_new) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (rank_ff[i] > rank_ff[tgt]) rank_ff[i] <= rank_ff[i] - 1'b1;
               end
               rank_ff[tgt] <= IW'(ENTRIES - 1);
            end
         end
         // One matching slot freed per cycle, lowest index first.
         if (cmd.del_step) begin
            used_ff[del_idx] <= 1'b0;
            refd_ff[del_idx] <= 1'b1;
            rhit_ff[del_idx] <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (rank_ff[i] < rank_ff[del_idx]) rank_ff[i] <= rank_ff[i] + 1'b1;
            end
            rank_ff[del_idx] <= '0;
            removed_ff <= removed_ff + 5'd1;
            status_ff  <= ST_DONE;
            slot_ff    <= '0;
         end
         if (cmd.match && req_ff == REQ_DELETE) begin
            status_ff <= ST_DONE;
            slot_ff   <= '0;
         end
      end
   end

endmodule

/* design/lru_name_range_table.sv */
// ----------------------------------------------------------------------------
// LRU name range table
// Fully associative name table with least recently used replacement.
// ----------------------------------------------------------------------------
// One request is handled at a time. A lookup, insert or clear passes through
// capture, compare, update and result; a delete passes through capture,
// compare, a sweep that frees one matching slot per step, and result, since the
// recency ranks are moved one freed slot at a time. The next request is accepted
// once the result transfer has completed.
module lru_name_range_table
   import lnrt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: req_type[2:0], insert_kind[4:3], var_name_high[36:5],
   // var_name_low[100:37], rel_name_high[132:101], rel_name_low[196:133],
   // relation_exists[197], zero fill to 200 bits
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: status[1:0], slot_index[6:2], removed_count[11:7], zero fill
   output logic [15:0]  rsp_tdata
);

   cmd_type    cmd;
   stat_type   stat;
   logic       is_delete;
   logic [1:0] status;
   logic [4:0] slot_index, removed_count;

   lnrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (req_tvalid && req_tready),
      .out_fire  (rsp_tvalid && rsp_tready),
      .is_delete (is_delete),
      .stat      (stat),
      .cmd       (cmd),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid)
   );

   lnrt_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_type_i   (req_tdata[2:0]),
      .kind_i       (req_tdata[4:3]),
      .vh_i         (req_tdata[36:5]),
      .vl_i         (req_tdata[100:37]),
      .rh_i         (req_tdata[132:101]),
      .rl_i         (req_tdata[196:133]),
      .rel_exists_i (req_tdata[197]),
      .stat         (stat),
      .is_delete    (is_delete),
      .status_o     (status),
      .slot_o       (slot_index),
      .removed_o    (removed_count)
   );

   // Result packing.
   assign rsp_tdata = {4'd0, removed_count, slot_index, status};

endmodule
